>>> src/altk_pkg.sv
// Shared types, constants and mnemonic table for the assembly line tokenizer.
package altk_pkg;

  // Operand and field widths
  localparam int OPERAND_BITS = 16;
  localparam int OPCODE_W     = 4;
  localparam int OPCNT_W      = 2;
  localparam int MAX_OPERANDS = 3;
  localparam int TOKLEN_W     = 5;
  localparam int HEAD_CHARS   = 4;
  localparam int HEAD_W       = 8 * HEAD_CHARS;
  localparam int NUM_MNEM     = 15;
  localparam int MLEN_W       = 3;

  localparam logic [TOKLEN_W-1:0] TOKLEN_MAX  = '1;
  localparam logic [TOKLEN_W-1:0] TOKLEN_HEAD = TOKLEN_W'(HEAD_CHARS);
  localparam logic [OPCNT_W-1:0]  OPCNT_FULL  = OPCNT_W'(MAX_OPERANDS);

  // Character codes
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_BRACKET = 8'h5B;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_LA      = 8'h61;
  localparam logic [7:0] CH_LF      = 8'h66;
  localparam logic [7:0] CH_UA      = 8'h41;
  localparam logic [7:0] CH_UF      = 8'h46;
  localparam logic [7:0] CH_LX      = 8'h78;
  localparam logic [7:0] CH_UX      = 8'h58;

  // Queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Number parser phase
  typedef enum logic [1:0] {
    PH_START,
    PH_ZERO,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  // One classified character
  typedef struct packed {
    logic [7:0] ch;
    logic       line_end;
    logic       is_space;
    logic       is_nul;
    logic       is_bracket;
    logic       is_hex;
    logic       is_zero;
    logic       is_x;
    logic [3:0] digit;
  } char_cls_t;

  // Mnemonic text, first character in the low byte, zero padded
  localparam logic [HEAD_W-1:0] MNEM_TEXT [NUM_MNEM] = '{
    32'h746C6168, // halt
    32'h00706F6E, // nop
    32'h00746573, // set
    32'h00706D6A, // jmp
    32'h007A636A, // jcz
    32'h00646461, // add
    32'h00627573, // sub
    32'h00646E61, // and
    32'h0000726F, // or
    32'h00726F78, // xor
    32'h00746F6E, // not
    32'h00706D63, // cmp
    32'h73627573, // subs
    32'h65627573, // sube
    32'h6C6C6163  // call
  };

  localparam logic [MLEN_W-1:0] MNEM_LEN [NUM_MNEM] = '{
    3'd4, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
    3'd2, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4
  };

endpackage

>>> src/assembly_line_tokenizer_unit.sv
// Top level of the assembly line tokenizer: front, queue and back end.
//
//   channel  direction  ports                         transfer when
//   in       input      in_text_char, in_line_end     in_valid & in_ready
//   out      output     out_opcode ... out_parse_error out_valid & out_ready
//
// One character per cycle is sustained while no line end waits on a stalled result;
// the token engine updates its state once per accepted character.
// A line's result is registered: its last character is held in a queue entry,
// and the back end then takes it from the queue entry into the result register.
// Reset is synchronous, active low, and clears all token and line state.
// A stalled result blocks the back end only at the next line end; the
// two-entry queue lets the input run on while the back end waits.
module assembly_line_tokenizer_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [7:0]                         in_text_char,
  input  logic                               in_line_end,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [altk_pkg::OPCODE_W-1:0]      out_opcode,
  output logic                               out_opcode_seen,
  output logic [altk_pkg::OPERAND_BITS-1:0]  out_operand_first,
  output logic [altk_pkg::OPERAND_BITS-1:0]  out_operand_second,
  output logic [altk_pkg::OPERAND_BITS-1:0]  out_operand_third,
  output logic [altk_pkg::OPCNT_W-1:0]       out_operand_count,
  output logic [2:0]                         out_indirect_mask,
  output logic                               out_parse_error
);
  import altk_pkg::*;

  char_cls_t front_cls;
  char_cls_t q_cls;
  logic      q_valid, q_ready;

  altk_front u_front (
    .in_text_char (in_text_char),
    .in_line_end  (in_line_end),
    .cls          (front_cls)
  );

  altk_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_data  (front_cls),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_cls)
  );

  altk_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cls_valid          (q_valid),
    .cls_ready          (q_ready),
    .cls                (q_cls),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_opcode         (out_opcode),
    .out_opcode_seen    (out_opcode_seen),
    .out_operand_first  (out_operand_first),
    .out_operand_second (out_operand_second),
    .out_operand_third  (out_operand_third),
    .out_operand_count  (out_operand_count),
    .out_indirect_mask  (out_indirect_mask),
    .out_parse_error    (out_parse_error)
  );

endmodule

>>> src/altk_front.sv
// Front end: classifies each incoming character for the token engine.
module altk_front (
  input  logic [7:0]         in_text_char,
  input  logic               in_line_end,
  output altk_pkg::char_cls_t cls
);
  import altk_pkg::*;

  logic is_dec, is_lhex, is_uhex;

  // Character class decode
  always_comb begin
    is_dec  = (in_text_char >= CH_ZERO) && (in_text_char <= CH_NINE);
    is_lhex = (in_text_char >= CH_LA) && (in_text_char <= CH_LF);
    is_uhex = (in_text_char >= CH_UA) && (in_text_char <= CH_UF);

    cls.ch         = in_text_char;
    cls.line_end   = in_line_end;
    cls.is_space   = (in_text_char == CH_SPACE);
    cls.is_nul     = (in_text_char == CH_NUL);
    cls.is_bracket = (in_text_char == CH_BRACKET);
    cls.is_hex     = is_dec || is_lhex || is_uhex;
    cls.is_zero    = (in_text_char == CH_ZERO);
    cls.is_x       = (in_text_char == CH_LX) || (in_text_char == CH_UX);
    if (is_dec) begin
      cls.digit = in_text_char[3:0];
    end else if (is_lhex || is_uhex) begin
      cls.digit = 4'(in_text_char[2:0] + 3'd1) + 4'd8;
    end else begin
      cls.digit = '0;
    end
  end

endmodule

>>> src/altk_queue.sv
// Short queue of classified characters between front and back.
module altk_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_ready,
  input  altk_pkg::char_cls_t push_data,
  output logic                pop_valid,
  input  logic                pop_ready,
  output altk_pkg::char_cls_t pop_data
);
  import altk_pkg::*;

  char_cls_t          ent_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic               push, pop;

  assign push_ready = (cnt_r != QCNT_W'(QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = ent_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("queue count exceeds depth");

  a_cnt_push: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(push && !pop) |-> cnt_r == $past(cnt_r) + 1'b1)
    else $error("queue count missed a push");

endmodule

>>> src/altk_back.sv
// Back end: token state, line state and the result register.
module altk_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cls_valid,
  output logic                               cls_ready,
  input  altk_pkg::char_cls_t                cls,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [altk_pkg::OPCODE_W-1:0]      out_opcode,
  output logic                               out_opcode_seen,
  output logic [altk_pkg::OPERAND_BITS-1:0]  out_operand_first,
  output logic [altk_pkg::OPERAND_BITS-1:0]  out_operand_second,
  output logic [altk_pkg::OPERAND_BITS-1:0]  out_operand_third,
  output logic [altk_pkg::OPCNT_W-1:0]       out_operand_count,
  output logic [2:0]                         out_indirect_mask,
  output logic                               out_parse_error
);
  import altk_pkg::*;

  // Token state
  logic [TOKLEN_W-1:0]     tok_len_r, tok_len_nxt;
  logic [HEAD_W-1:0]       tok_head_r, tok_head_nxt;
  logic [OPERAND_BITS-1:0] acc_r, acc_nxt;
  phase_t                  phase_r, phase_nxt;
  logic                    bracket_r, bracket_nxt;
  logic                    first_hex_r, first_hex_nxt;

  // Line state
  logic [OPCNT_W-1:0]      idx_r, idx_nxt;
  logic [OPERAND_BITS-1:0] ops_r [MAX_OPERANDS];
  logic [OPERAND_BITS-1:0] ops_nxt [MAX_OPERANDS];
  logic [OPCODE_W-1:0]     opc_r, opc_nxt;
  logic                    seen_r, seen_nxt;
  logic                    err_r, err_nxt;
  logic [2:0]              ind_r, ind_nxt;
  logic                    nul_r, nul_nxt;

  // Result register
  logic                    out_valid_r;
  logic [OPCODE_W-1:0]     out_opcode_r;
  logic                    out_seen_r;
  logic [OPERAND_BITS-1:0] out_op0_r, out_op1_r, out_op2_r;
  logic [OPCNT_W-1:0]      out_cnt_r;
  logic [2:0]              out_ind_r;
  logic                    out_err_r;

  logic                    take, finish, stopped, pop, load;
  logic                    mnem_hit;
  logic [OPCODE_W-1:0]     mnem_idx;
  logic [2:0]              ind_used;

  assign pop       = cls_valid && cls_ready;
  assign load      = pop && cls.line_end;
  assign cls_ready = !cls.line_end || !out_valid_r || out_ready;

  // Token update for the current character, before any token finish
  always_comb begin
    tok_len_nxt   = tok_len_r;
    tok_head_nxt  = tok_head_r;
    acc_nxt       = acc_r;
    phase_nxt     = phase_r;
    bracket_nxt   = bracket_r;
    first_hex_nxt = first_hex_r;
    take          = !nul_r && !cls.is_nul && !cls.is_space;
    if (take) begin
      if (tok_len_r == '0) begin
        bracket_nxt   = cls.is_bracket;
        first_hex_nxt = cls.is_hex;
      end
      if (tok_len_r != '0 || !cls.is_bracket) begin
        case (phase_r)
          PH_START: begin
            if (!cls.is_hex) begin
              phase_nxt = PH_DONE;
            end else if (cls.is_zero) begin
              phase_nxt = PH_ZERO;
            end else begin
              acc_nxt   = OPERAND_BITS'(cls.digit);
              phase_nxt = PH_DIGITS;
            end
          end
          PH_ZERO: begin
            if (cls.is_x) begin
              phase_nxt = PH_DIGITS;
            end else if (cls.is_hex) begin
              acc_nxt   = OPERAND_BITS'(cls.digit);
              phase_nxt = PH_DIGITS;
            end else begin
              phase_nxt = PH_DONE;
            end
          end
          PH_DIGITS: begin
            if (cls.is_hex) begin
              acc_nxt = {acc_r[OPERAND_BITS-5:0], cls.digit};
            end else begin
              phase_nxt = PH_DONE;
            end
          end
          default: begin
            phase_nxt = phase_r;
          end
        endcase
      end
      if (tok_len_r < TOKLEN_HEAD) begin
        tok_head_nxt = tok_head_r | (HEAD_W'(cls.ch) << {tok_len_r[1:0], 3'b000});
      end
      if (tok_len_r != TOKLEN_MAX) begin
        tok_len_nxt = tok_len_r + 1'b1;
      end
    end
  end

  // Mnemonic compare on the updated token head
  always_comb begin
    mnem_hit = 1'b0;
    mnem_idx = '0;
    for (int k = NUM_MNEM - 1; k >= 0; k--) begin
      if (tok_len_nxt == TOKLEN_W'(MNEM_LEN[k]) && tok_head_nxt == MNEM_TEXT[k]) begin
        mnem_hit = 1'b1;
        mnem_idx = OPCODE_W'(k);
      end
    end
  end

  // Token finish and line update
  always_comb begin
    idx_nxt  = idx_r;
    ops_nxt  = ops_r;
    opc_nxt  = opc_r;
    seen_nxt = seen_r;
    err_nxt  = err_r;
    ind_nxt  = ind_r;
    nul_nxt  = nul_r || cls.is_nul;
    stopped  = err_r || nul_r || (idx_r == OPCNT_FULL);
    finish   = (tok_len_nxt != '0) &&
               (cls.line_end || (!nul_r && (cls.is_space || cls.is_nul)));
    if (finish && !stopped) begin
      if (mnem_hit) begin
        opc_nxt  = mnem_idx;
        seen_nxt = 1'b1;
      end else if (first_hex_nxt || bracket_nxt) begin
        ops_nxt[idx_r] = acc_nxt;
        if (bracket_nxt) begin
          case (idx_r)
            2'd0:    ind_nxt[2] = 1'b1;
            2'd1:    ind_nxt[1] = 1'b1;
            default: ind_nxt[0] = 1'b1;
          endcase
        end
        idx_nxt = idx_r + 1'b1;
      end else begin
        err_nxt = 1'b1;
      end
    end
  end

  // Token and line registers
  always_ff @(posedge clk) begin
    if (!rst_n || load) begin
      idx_r  <= '0;
      opc_r  <= '0;
      seen_r <= 1'b0;
      err_r  <= 1'b0;
      ind_r  <= '0;
      nul_r  <= 1'b0;
      for (int i = 0; i < MAX_OPERANDS; i++) begin
        ops_r[i] <= '0;
      end
    end else if (pop) begin
      idx_r  <= idx_nxt;
      opc_r  <= opc_nxt;
      seen_r <= seen_nxt;
      err_r  <= err_nxt;
      ind_r  <= ind_nxt;
      nul_r  <= nul_nxt;
      ops_r  <= ops_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || load || (pop && finish)) begin
      tok_len_r   <= '0;
      tok_head_r  <= '0;
      acc_r       <= '0;
      phase_r     <= PH_START;
      bracket_r   <= 1'b0;
      first_hex_r <= 1'b0;
    end else if (pop) begin
      tok_len_r   <= tok_len_nxt;
      tok_head_r  <= tok_head_nxt;
      acc_r       <= acc_nxt;
      phase_r     <= phase_nxt;
      bracket_r   <= bracket_nxt;
      first_hex_r <= first_hex_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_opcode_r <= opc_nxt;
      out_seen_r   <= seen_nxt;
      out_op0_r    <= ops_nxt[0];
      out_op1_r    <= ops_nxt[1];
      out_op2_r    <= ops_nxt[2];
      out_cnt_r    <= idx_nxt;
      out_ind_r    <= ind_nxt;
      out_err_r    <= err_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_opcode         = out_opcode_r;
  assign out_opcode_seen    = out_seen_r;
  assign out_operand_first  = out_op0_r;
  assign out_operand_second = out_op1_r;
  assign out_operand_third  = out_op2_r;
  assign out_operand_count  = out_cnt_r;
  assign out_indirect_mask  = out_ind_r;
  assign out_parse_error    = out_err_r;

  // Indirect bits that the current operand count allows
  always_comb begin
    case (idx_r)
      2'd0:    ind_used = 3'b000;
      2'd1:    ind_used = 3'b100;
      2'd2:    ind_used = 3'b110;
      default: ind_used = 3'b111;
    endcase
  end

  a_line_clear: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (idx_r == '0) && !nul_r && !err_r && !seen_r && (ind_r == '0))
    else $error("line state not cleared after result");

  a_ind_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ind_r & ~ind_used) == '0)
    else $error("indirect bit set beyond operand count");

endmodule

>>> verif/tb_assembly_line_tokenizer_unit.sv
// Self-checking testbench for the assembly line tokenizer: random lines, predictor, checker.
`timescale 1ns / 100ps

module tb_assembly_line_tokenizer_unit;
  import altk_pkg::*;

  localparam int RANDOM_ITEMS = 1800;
  localparam int TAIL_ITEMS   = 150;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 400000;

  // One character transfer on the input channel
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_item_t;

  // Fields of one line's result
  typedef struct {
    logic [OPCODE_W-1:0]     opcode;
    logic                    seen;
    logic [OPERAND_BITS-1:0] first;
    logic [OPERAND_BITS-1:0] second;
    logic [OPERAND_BITS-1:0] third;
    logic [OPCNT_W-1:0]      count;
    logic [2:0]              mask;
    logic                    err;
  } line_result_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [7:0]              in_text_char = '0;
  logic                    in_line_end = 1'b0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [OPCODE_W-1:0]     out_opcode;
  logic                    out_opcode_seen;
  logic [OPERAND_BITS-1:0] out_operand_first;
  logic [OPERAND_BITS-1:0] out_operand_second;
  logic [OPERAND_BITS-1:0] out_operand_third;
  logic [OPCNT_W-1:0]      out_operand_count;
  logic [2:0]              out_indirect_mask;
  logic                    out_parse_error;

  // Mnemonic spellings; the opcode is the position in this list
  string mnemonics [NUM_MNEM] = '{"halt", "nop", "set", "jmp", "jcz", "add", "sub",
                                  "and", "or", "xor", "not", "cmp", "subs", "sube", "call"};
  string hex_chars = "0123456789abcdefABCDEF";

  text_item_t   pending_chars [$];
  logic [7:0]   line_bytes [$];
  line_result_t line_results_q [$];
  int           mismatches = 0;
  int           cycle_count = 0;
  logic         calm_tail = 1'b0;

  // Tokenizer state mirrored by the predictor
  logic [TOKLEN_W-1:0]     tok_len = '0;
  logic [HEAD_W-1:0]       tok_head = '0;
  logic [OPERAND_BITS-1:0] num_acc = '0;
  phase_t                  num_phase = PH_START;
  logic                    tok_bracket = 1'b0;
  logic [OPCNT_W-1:0]      opnd_idx = '0;
  logic [OPERAND_BITS-1:0] opnd [MAX_OPERANDS] = '{default: '0};
  logic [OPCODE_W-1:0]     line_opcode = '0;
  logic                    line_seen = 1'b0;
  logic                    line_err = 1'b0;
  logic [2:0]              line_mask = '0;
  logic                    nul_seen = 1'b0;

  assembly_line_tokenizer_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_text_char       (in_text_char),
    .in_line_end        (in_line_end),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_opcode         (out_opcode),
    .out_opcode_seen    (out_opcode_seen),
    .out_operand_first  (out_operand_first),
    .out_operand_second (out_operand_second),
    .out_operand_third  (out_operand_third),
    .out_operand_count  (out_operand_count),
    .out_indirect_mask  (out_indirect_mask),
    .out_parse_error    (out_parse_error)
  );

  always #5 clk = ~clk;

  // Hex digit value, -1 for any other character
  function automatic int hex_digit(logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
    if (c >= CH_LA && c <= CH_LF) return int'(c - CH_LA) + 10;
    if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
    return -1;
  endfunction

  // Index of the mnemonic spelled by the current token, -1 if none
  function automatic int mnemonic_index();
    int  k;
    int  j;
    bit  same;
    if (tok_len > TOKLEN_HEAD) return -1;
    for (k = 0; k < NUM_MNEM; k++) begin
      same = (mnemonics[k].len() == int'(tok_len));
      for (j = 0; same && j < int'(tok_len); j++)
        if (tok_head[8*j +: 8] != mnemonics[k][j]) same = 1'b0;
      if (same) return k;
    end
    return -1;
  endfunction

  // strtoul-style base-16 scan, one character at a time
  task automatic scan_number(logic [7:0] c);
    int d;
    d = hex_digit(c);
    case (num_phase)
      PH_START: begin
        if (d < 0) num_phase = PH_DONE;
        else if (c == CH_ZERO) num_phase = PH_ZERO;
        else begin
          num_acc = OPERAND_BITS'(d);
          num_phase = PH_DIGITS;
        end
      end
      PH_ZERO: begin
        if (c == CH_LX || c == CH_UX) num_phase = PH_DIGITS;
        else if (d >= 0) begin
          num_acc = OPERAND_BITS'(d);
          num_phase = PH_DIGITS;
        end else num_phase = PH_DONE;
      end
      PH_DIGITS: begin
        if (d >= 0) num_acc = {num_acc[OPERAND_BITS-5:0], 4'(d)};
        else num_phase = PH_DONE;
      end
      default: ;
    endcase
  endtask

  // Close the token in progress and fold it into the line
  task automatic close_token();
    int m;
    if (tok_len != 0) begin
      if (!(line_err || nul_seen || opnd_idx == OPCNT_FULL)) begin
        m = mnemonic_index();
        if (m >= 0) begin
          line_opcode = OPCODE_W'(m);
          line_seen = 1'b1;
        end else if (hex_digit(tok_head[7:0]) >= 0 || tok_bracket) begin
          opnd[opnd_idx] = num_acc;
          if (tok_bracket) line_mask[2 - opnd_idx] = 1'b1;
          opnd_idx++;
        end else line_err = 1'b1;
      end
      tok_len = '0;
      tok_head = '0;
      num_acc = '0;
      num_phase = PH_START;
      tok_bracket = 1'b0;
    end
  endtask

  // Advance the predictor by one accepted character; a line end queues its result
  task automatic predict_char(logic [7:0] c, logic last);
    line_result_t r;
    if (!nul_seen) begin
      if (c == CH_NUL) begin
        close_token();
        nul_seen = 1'b1;
      end else if (c == CH_SPACE) close_token();
      else begin
        if (tok_len == 0) begin
          tok_bracket = (c == CH_BRACKET);
          if (!tok_bracket) scan_number(c);
        end else scan_number(c);
        if (tok_len < TOKLEN_HEAD) tok_head[8*tok_len +: 8] = c;
        if (tok_len != TOKLEN_MAX) tok_len++;
      end
    end
    if (last) begin
      close_token();
      r.opcode = line_seen ? line_opcode : '0;
      r.seen   = line_seen;
      r.first  = opnd[0];
      r.second = opnd[1];
      r.third  = opnd[2];
      r.count  = opnd_idx;
      r.mask   = line_mask;
      r.err    = line_err;
      line_results_q.push_back(r);
      opnd_idx = '0;
      opnd = '{default: '0};
      line_opcode = '0;
      line_seen = 1'b0;
      line_err = 1'b0;
      line_mask = '0;
      nul_seen = 1'b0;
    end
  endtask

  // Line building
  task automatic put_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
  endtask

  task automatic end_line();
    text_item_t it;
    while (line_bytes.size() > 0) begin
      it.ch = line_bytes.pop_front();
      it.last = (line_bytes.size() == 0);
      pending_chars.push_back(it);
    end
  endtask

  function automatic logic [7:0] any_nonspace();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == CH_SPACE);
    return c;
  endfunction

  // Hex number text: optional prefix, up to six digits (wraps past four)
  task automatic put_number(bit need_lead);
    int pfx;
    int ndig;
    int i;
    pfx = $urandom_range(0, 3);
    ndig = $urandom_range(0, 6);
    if (need_lead && pfx == 0 && ndig == 0) ndig = 1;
    case (pfx)
      1: put_text("0x");
      2: put_text("0X");
      3: put_text("0");
      default: ;
    endcase
    for (i = 0; i < ndig; i++) line_bytes.push_back(hex_chars[$urandom_range(0, 21)]);
    if ($urandom_range(0, 7) == 0) line_bytes.push_back(any_nonspace());
  endtask

  // One random line: mostly well-formed tokens, some noise and broken tokens
  task automatic gen_line(int line_no);
    int    ntok;
    int    t;
    int    kind;
    int    i;
    string s;
    if ($urandom_range(0, 14) == 0) begin
      for (i = $urandom_range(1, 8); i > 0; i--) line_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      if ($urandom_range(0, 5) == 0) put_text("  ");
      ntok = $urandom_range(1, 5);
      for (t = 0; t < ntok; t++) begin
        if (t > 0) for (i = $urandom_range(1, 3); i > 0; i--) line_bytes.push_back(CH_SPACE);
        kind = (line_no < NUM_MNEM && t == 0) ? 0 : $urandom_range(0, 99);
        if (kind < 30) begin
          put_text(mnemonics[(line_no < NUM_MNEM) ? line_no : $urandom_range(0, NUM_MNEM - 1)]);
        end else if (kind < 55) put_number(1'b1);
        else if (kind < 70) begin
          line_bytes.push_back(CH_BRACKET);
          // sign or blank after the bracket reads as zero
          case ($urandom_range(0, 9))
            0: put_text("-");
            1: put_text("+");
            default: ;
          endcase
          put_number(1'b0);
        end else if (kind < 82) begin
          // near miss: one letter too many or too few
          s = mnemonics[$urandom_range(0, NUM_MNEM - 1)];
          if ($urandom_range(0, 1) == 0) s = {s, string'(8'($urandom_range(8'h61, 8'h7A)))};
          else s = s.substr(0, s.len() - 2);
          put_text(s);
        end else begin
          for (i = $urandom_range(1, 6); i > 0; i--) line_bytes.push_back(any_nonspace());
        end
      end
      if ($urandom_range(0, 11) == 0) begin
        line_bytes.push_back(CH_NUL);
        for (i = $urandom_range(0, 4); i > 0; i--) line_bytes.push_back(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 5) == 0) put_text(" ");
    end
    end_line();
  endtask

  // Driver: one character per transfer, with random idle bursts
  always @(posedge clk) begin : drive
    text_item_t item;
    static int in_gap = 0;
    static int in_quiet = 0;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_char(in_text_char, in_line_end);
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_valid <= 1'b0;
          in_gap--;
        end else if (!calm_tail && in_quiet == 0 && $urandom_range(0, 9) == 0) begin
          in_valid <= 1'b0;
          in_gap = $urandom_range(1, 17) - 1;
        end else if (pending_chars.size() > 0) begin
          item = pending_chars.pop_front();
          in_valid <= 1'b1;
          in_text_char <= item.ch;
          in_line_end <= item.last;
          if (in_quiet > 0) in_quiet--;
          else if ($urandom_range(0, 39) == 0) in_quiet = $urandom_range(20, 80);
        end else begin
          in_valid <= 1'b0;
        end
      end
      calm_tail <= (pending_chars.size() < TAIL_ITEMS);
    end
  end

  task automatic check_field(string field, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      mismatches++;
    end
  endtask

  // Monitor: compare each result transfer with the oldest predicted line
  always @(posedge clk) begin : watch
    line_result_t want;
    static int out_gap = 0;
    static int out_quiet = 0;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (line_results_q.size() == 0) begin
          $error("result transfer with no line pending");
          mismatches++;
        end else begin
          want = line_results_q.pop_front();
          check_field("opcode", want.opcode, out_opcode);
          check_field("opcode_seen", want.seen, out_opcode_seen);
          check_field("operand_first", want.first, out_operand_first);
          check_field("operand_second", want.second, out_operand_second);
          check_field("operand_third", want.third, out_operand_third);
          check_field("operand_count", want.count, out_operand_count);
          check_field("indirect_mask", want.mask, out_indirect_mask);
          check_field("parse_error", want.err, out_parse_error);
        end
      end
      if (out_gap > 0) begin
        out_ready <= 1'b0;
        out_gap--;
      end else if (!calm_tail && out_quiet == 0 && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        out_gap = $urandom_range(1, 17) - 1;
      end else begin
        out_ready <= 1'b1;
        if (out_quiet > 0) out_quiet--;
        else if ($urandom_range(0, 29) == 0) out_quiet = $urandom_range(10, 60);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Stimulus and end of run
  initial begin : stimulus
    int line_no;
    int directed_chars;
    // 0xFF alone: unknown token
    line_bytes.push_back(8'hFF);
    end_line();
    // extra spaces, bare 0x, lone bracket, NUL ending the text
    put_text(" or  0x [ ");
    line_bytes.push_back(CH_NUL);
    put_text("z");
    end_line();
    // signed bracket operand, then a five-letter near mnemonic
    put_text("[-5 halts");
    end_line();
    // wrap past 16 bits, third operand stops the line
    put_text("[ FFFFF 2 3 add");
    end_line();
    directed_chars = pending_chars.size();
    line_no = 0;
    while (pending_chars.size() < directed_chars + RANDOM_ITEMS) begin
      gen_line(line_no);
      line_no++;
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_chars.size() != 0 || in_valid || line_results_q.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
